// ===== hw/rtl/sgpg_pkg.sv =====
// Shared types and constants for the skip-gram pair generator.
// Holds the sequencer state encoding and the read request passed to the word ring.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgpg_pkg;

  // Ages and offsets fit these widths for every supported radius
  localparam int AGE_W = 4;
  localparam int SW    = AGE_W + 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  typedef struct packed {
    logic             en;
    logic [AGE_W-1:0] centre_age;
    logic [AGE_W-1:0] context_age;
    logic             run_last;
    logic             corpus_end;
  } rd_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skipgram_pair_generator_unit.sv =====
// Skip-gram pair generator top level: radius register, sequencer, word ring, output stage.
// Uses sgpg_pkg, sgpg_seq and sgpg_ring.
// The first pair reaches the output register after the sequencer has entered its run state for the accepted word.
// Throughput: one pair per cycle from the shared sequencer while the output does not stall; a new
// word is taken only after the last pair of the previous word has been issued.
// Output register stalls the sequencer only while a pair waits for out_ready.
// Reset (synchronous, rst high) clears control state and sets the radius to 1.
`timescale 1ns / 1ps
`default_nettype none

module skipgram_pair_generator_unit #(
  parameter int MAX_RADIUS = 4,
  parameter int VOCAB_BITS = 20
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_wr_en,
  input  wire [2:0]             cfg_wr_data,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire [VOCAB_BITS-1:0]  word_index,
  input  wire                   corpus_last,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [VOCAB_BITS-1:0] centre_word,
  output logic [VOCAB_BITS-1:0] context_word,
  output logic                  run_last,
  output logic                  corpus_end
);

  logic [2:0]        window_radius;
  logic              adv;
  logic              accept;
  sgpg_pkg::rd_req_t req;

  assign adv    = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_radius <= 3'd1;
    end else if (cfg_wr_en) begin
      window_radius <= cfg_wr_data;
    end
  end

  sgpg_seq #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .radius_cfg (window_radius),
    .in_valid   (in_valid),
    .in_last    (corpus_last),
    .in_ready   (in_ready),
    .adv        (adv),
    .req        (req)
  );

  sgpg_ring #(
    .MAX_RADIUS (MAX_RADIUS),
    .VOCAB_BITS (VOCAB_BITS)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (accept),
    .wr_word      (word_index),
    .req          (req),
    .centre_word  (centre_word),
    .context_word (context_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      run_last   <= req.run_last;
      corpus_end <= req.corpus_end;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgpg_ring.sv =====
// Circular word store of the last 2*MAX_RADIUS+1 corpus words.
// Maps word ages to addresses and registers both read words. Uses sgpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgpg_ring #(
  parameter int MAX_RADIUS = 4,
  parameter int VOCAB_BITS = 20
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        wr_en,
  input  wire [VOCAB_BITS-1:0]       wr_word,
  input  sgpg_pkg::rd_req_t          req,
  output logic [VOCAB_BITS-1:0]      centre_word,
  output logic [VOCAB_BITS-1:0]      context_word
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam logic [IW:0] DEPTH_C = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_C = IW'(DEPTH - 1);

  logic [VOCAB_BITS-1:0] mem [DEPTH];
  logic [IW-1:0] wp;
  logic [IW-1:0] wp_next;
  logic [IW-1:0] centre_addr;
  logic [IW-1:0] context_addr;

  function automatic logic [IW-1:0] age_to_addr(input logic [IW-1:0] ptr,
                                                input logic [IW-1:0] age);
    logic [IW:0] sum;
    sum = {1'b0, ptr} + DEPTH_C - {1'b0, age};
    if (sum >= DEPTH_C) begin
      sum = sum - DEPTH_C;
    end
    return sum[IW-1:0];
  endfunction

  assign wp_next      = (wp == LAST_C) ? '0 : wp + IW'(1);
  assign centre_addr  = age_to_addr(wp, req.centre_age[IW-1:0]);
  assign context_addr = age_to_addr(wp, req.context_age[IW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (wr_en) begin
      wp <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_next] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      centre_word  <= mem[centre_addr];
      context_word <= mem[context_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgpg_seq.sv =====
// Pair sequencer: steps centre age and context offset one pair per cycle while adv is high.
// Tracks fill count and radius per transaction. Uses sgpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgpg_seq #(
  parameter int MAX_RADIUS = 4
) (
  input  wire               clk,
  input  wire               rst,
  input  wire [2:0]         radius_cfg,
  input  wire               in_valid,
  input  wire               in_last,
  output logic              in_ready,
  input  wire               adv,
  output sgpg_pkg::rd_req_t req
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int FW    = $clog2(DEPTH);
  localparam int SW    = sgpg_pkg::SW;
  localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH - 1);
  localparam logic [2:0]    RMAX_C   = 3'(MAX_RADIUS);

  sgpg_pkg::seq_state_t state, state_next;

  logic [FW-1:0]          fill, fill_next;
  logic signed [SW-1:0]   radius, radius_next;
  logic signed [SW-1:0]   avail, avail_next;
  logic                   last, last_next;
  logic signed [SW-1:0]   age, age_next;
  logic signed [SW-1:0]   off, off_next;

  logic [2:0]             r_eff;
  logic signed [SW-1:0]   r_in;
  logic signed [SW-1:0]   fill_s;
  logic signed [SW-1:0]   first_age;
  logic signed [SW-1:0]   ctx_age;
  logic signed [SW-1:0]   off_inc;
  logic signed [SW-1:0]   hi;
  logic                   accept;
  logic                   pair_last;

  function automatic logic signed [SW-1:0] low_off(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] r,
                                                   input logic signed [SW-1:0] av);
    logic signed [SW-1:0] t;
    t = a - av;
    if (t < -r) begin
      t = -r;
    end
    if (t == '0) begin
      t = SW'(1);
    end
    return t;
  endfunction

  always_comb begin
    if (radius_cfg == 3'd0) begin
      r_eff = 3'd1;
    end else if (radius_cfg > RMAX_C) begin
      r_eff = RMAX_C;
    end else begin
      r_eff = radius_cfg;
    end
  end

  assign r_in     = signed'({{(SW-3){1'b0}}, r_eff});
  assign fill_s   = signed'({{(SW-FW){1'b0}}, fill});
  assign in_ready = (state == sgpg_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ctx_age  = age - off;
  assign hi       = (age < radius) ? age : radius;
  assign first_age = in_last ? ((fill_s < r_in) ? fill_s : r_in) : r_in;

  always_comb begin
    off_inc = off + SW'(1);
    if (off_inc == '0) begin
      off_inc = SW'(1);
    end
  end

  always_comb begin
    if (last) begin
      pair_last = (age == '0) && (off == -SW'(1));
    end else begin
      pair_last = (off == radius);
    end
  end

  always_comb begin
    req.en          = (state == sgpg_pkg::ST_RUN) && adv;
    req.centre_age  = age[sgpg_pkg::AGE_W-1:0];
    req.context_age = ctx_age[sgpg_pkg::AGE_W-1:0];
    req.run_last    = pair_last;
    req.corpus_end  = pair_last && last;
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    radius_next = radius;
    avail_next  = avail;
    last_next   = last;
    age_next    = age;
    off_next    = off;
    case (state)
      sgpg_pkg::ST_IDLE: begin
        if (accept) begin
          radius_next = r_in;
          avail_next  = fill_s;
          last_next   = in_last;
          age_next    = first_age;
          off_next    = low_off(first_age, r_in, fill_s);
          if (in_last) begin
            fill_next = '0;
          end else if (fill != FILL_MAX) begin
            fill_next = fill + FW'(1);
          end
          if (in_last ? (fill_s != '0) : (fill_s >= r_in)) begin
            state_next = sgpg_pkg::ST_RUN;
          end
        end
      end
      sgpg_pkg::ST_RUN: begin
        if (adv) begin
          if (pair_last) begin
            state_next = sgpg_pkg::ST_IDLE;
          end else if (off_inc > hi) begin
            age_next = age - SW'(1);
            off_next = low_off(age - SW'(1), radius, avail);
          end else begin
            off_next = off_inc;
          end
        end
      end
      default: begin
        state_next = sgpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgpg_pkg::ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    radius <= radius_next;
    avail  <= avail_next;
    last   <= last_next;
    age    <= age_next;
    off    <= off_next;
  end

  a_off_nonzero : assert property (@(posedge clk) disable iff (rst)
    state == sgpg_pkg::ST_RUN |-> off != '0)
    else $error("context offset zero while running");

  a_flush_clears_fill : assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> fill == '0)
    else $error("fill count not cleared after last word");

  a_ctx_in_range : assert property (@(posedge clk) disable iff (rst)
    req.en |-> (ctx_age >= '0) && (ctx_age <= avail))
    else $error("context age outside held words");

endmodule

`default_nettype wire

// ===== sim/skipgram_pair_generator_unit_test.sv =====
// Self-checking testbench for the skip-gram pair generator unit.
// Feeds word transactions and compares every pair against an internal predictor.
// Depends only on skipgram_pair_generator_unit and the RTL it instantiates.
`timescale 1ns / 1ps

module skipgram_pair_generator_unit_test;

  localparam int MAX_RADIUS    = 4;
  localparam int WORD_W        = 20;
  localparam int RING_DEPTH    = 2 * MAX_RADIUS + 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 80;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } corpus_word_t;

  typedef struct {
    logic [WORD_W-1:0] centre_w;
    logic [WORD_W-1:0] neighbor_w;
    logic              run_last;
    logic              corpus_end;
  } skip_pair_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              cfg_wr_en    = 1'b0;
  logic [2:0]        cfg_wr_data  = 3'd0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] word_index   = '0;
  logic              corpus_last  = 1'b0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [WORD_W-1:0] centre_word;
  logic [WORD_W-1:0] context_word;
  logic              run_last;
  logic              corpus_end;

  corpus_word_t word_backlog[$];
  skip_pair_t   pending_pairs[$];

  logic [WORD_W-1:0] word_ring [RING_DEPTH];
  int                held_count     = 0;
  logic [2:0]        radius_setting = 3'd1;

  int       errors         = 0;
  int       words_sent     = 0;
  int       words_queued   = 0;
  int       corpora_queued = 0;
  int       pairs_checked  = 0;
  int       ends_seen      = 0;
  bit [7:0] radii_seen     = '0;
  int       send_idle_odds = 25;
  int       recv_idle_odds = 25;
  int       gap_left       = 0;
  int       stall_left     = 0;
  int       hold_left      = 0;
  bit       hold_armed     = 1'b0;
  bit       hold_done      = 1'b0;

  skipgram_pair_generator_unit #(
    .MAX_RADIUS(MAX_RADIUS),
    .VOCAB_BITS(WORD_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .word_index  (word_index),
    .corpus_last (corpus_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .centre_word (centre_word),
    .context_word(context_word),
    .run_last    (run_last),
    .corpus_end  (corpus_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic predict_pairs(input logic [WORD_W-1:0] w, input logic last);
    int         r;
    int         avail;
    int         a;
    int         i;
    int         cage;
    skip_pair_t batch[$];
    skip_pair_t p;
    r = (radius_setting == 3'd0) ? 1 :
        ((radius_setting > MAX_RADIUS) ? MAX_RADIUS : int'(radius_setting));
    avail = held_count;
    for (i = RING_DEPTH - 1; i > 0; i--) word_ring[i] = word_ring[i-1];
    word_ring[0] = w;
    for (a = r; a >= (last ? 0 : r); a--) begin
      if (a <= avail) begin
        for (i = -r; i <= r; i++) begin
          cage = a - i;
          if (i != 0 && cage >= 0 && cage <= avail) begin
            p.centre_w   = word_ring[a];
            p.neighbor_w = word_ring[cage];
            p.run_last   = 1'b0;
            p.corpus_end = 1'b0;
            batch = {batch, p};
          end
        end
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].run_last   = 1'b1;
      batch[batch.size()-1].corpus_end = last;
    end
    pending_pairs = {pending_pairs, batch};
    if (last) held_count = 0;
    else if (held_count < RING_DEPTH - 1) held_count++;
  endtask

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // word transactions; hold the payload until accepted
  always @(posedge clk) begin : drive_words
    corpus_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        predict_pairs(word_index, corpus_last);
        words_sent++;
      end
      if (in_valid && send_idle_odds > 0 && $urandom_range(1, 100) <= send_idle_odds) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 2);
      end else if (!in_valid && gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (word_backlog.size() > 0) begin
        nxt = word_backlog.pop_front();
        word_index  <= nxt.word;
        corpus_last <= nxt.last;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD - 1;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_idle_odds > 0 && $urandom_range(1, 100) <= recv_idle_odds) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_pairs
    skip_pair_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair: centre_word %0h, context_word %0h", centre_word, context_word);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (corpus_end) ends_seen++;
        check_field("centre_word", want.centre_w, centre_word);
        check_field("context_word", want.neighbor_w, context_word);
        check_field("run_last", WORD_W'(want.run_last), WORD_W'(run_last));
        check_field("corpus_end", WORD_W'(want.corpus_end), WORD_W'(corpus_end));
      end
    end
  end

  task automatic queue_word(input logic [WORD_W-1:0] w, input logic last);
    corpus_word_t item;
    item.word = w;
    item.last = last;
    word_backlog = {word_backlog, item};
    words_queued++;
    if (last) corpora_queued++;
  endtask

  task automatic queue_corpus(input int len, input bit close);
    int k;
    for (k = 0; k < len; k++)
      queue_word(WORD_W'($urandom_range(0, (1 << WORD_W) - 1)), close && (k == len - 1));
  endtask

  // wait for the backlog and every pair, then let the sequencer go quiet
  task automatic settle();
    @(posedge clk);
    #1;
    while (word_backlog.size() != 0 || in_valid || pending_pairs.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
  endtask

  task automatic set_radius(input logic [2:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    radius_setting = v;
    radii_seen[v]  = 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    #1;
  endtask

  initial begin : stimulus
    int  k;
    bit  first;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    #1;

    queue_word('1, 1'b1);
    queue_word('0, 1'b0);
    queue_word('1, 1'b0);
    queue_word(20'h55555, 1'b0);
    queue_word(20'hAAAAA, 1'b1);
    settle();

    set_radius(3'd4);
    for (k = 0; k < 10; k++)
      queue_word((k == 0) ? '0 :
                 ((k == 9) ? '1 : WORD_W'($urandom_range(0, (1 << WORD_W) - 1))),
                 k == 9);
    settle();

    set_radius(3'd7);
    queue_corpus(3, 1'b1);
    settle();

    set_radius(3'd0);
    queue_corpus(2, 1'b1);
    settle();

    set_radius(3'd2);
    queue_corpus(3, 1'b0);
    settle();
    set_radius(3'd3);
    queue_corpus(2, 1'b1);
    settle();

    first = 1'b1;
    while (words_queued < 115) begin
      set_radius(3'($urandom_range(0, 7)));
      send_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 25;
      recv_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 25;
      if (first) hold_armed = 1'b1;
      first = 1'b0;
      repeat ($urandom_range(1, 4)) queue_corpus($urandom_range(1, 14), 1'b1);
      if ($urandom_range(0, 3) == 0) queue_corpus($urandom_range(1, 6), 1'b0);
      settle();
    end

    send_idle_odds = 0;
    recv_idle_odds = 0;
    set_radius(3'd5);
    queue_corpus(12, 1'b1);
    queue_corpus(8, 1'b1);
    settle();

    $display("run covered %0d words in %0d corpora, %0d pairs checked, %0d corpus ends",
             words_sent, corpora_queued, pairs_checked, ends_seen);
    $display("radius codes written: %b, long output stall applied: %0d", radii_seen, hold_done);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
